### hdl/drf_pkg.sv
// DES round function package: field widths, expansion, permutation and S-box tables,
// and the helper functions that apply them.
// No dependencies.
package drf_pkg;

  localparam int unsigned HalfW = 32;
  localparam int unsigned KeyW  = 48;
  localparam int unsigned NumSbox = 8;

  typedef logic [HalfW-1:0] half_t;
  typedef logic [KeyW-1:0]  key_t;

  // DES positions, 1 = MSB
  localparam logic [5:0] ExpandTab [KeyW] = '{
    6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
    6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
    6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
  };

  localparam logic [5:0] PermTab [HalfW] = '{
    6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
    6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
    6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
    6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
  };

  localparam logic [3:0] SboxTab [NumSbox][64] = '{
    '{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
      4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7,
      4'd0, 4'd15, 4'd7, 4'd4, 4'd14, 4'd2, 4'd13, 4'd1,
      4'd10, 4'd6, 4'd12, 4'd11, 4'd9, 4'd5, 4'd3, 4'd8,
      4'd4, 4'd1, 4'd14, 4'd8, 4'd13, 4'd6, 4'd2, 4'd11,
      4'd15, 4'd12, 4'd9, 4'd7, 4'd3, 4'd10, 4'd5, 4'd0,
      4'd15, 4'd12, 4'd8, 4'd2, 4'd4, 4'd9, 4'd1, 4'd7,
      4'd5, 4'd11, 4'd3, 4'd14, 4'd10, 4'd0, 4'd6, 4'd13},
    '{4'd15, 4'd1, 4'd8, 4'd14, 4'd6, 4'd11, 4'd3, 4'd4,
      4'd9, 4'd7, 4'd2, 4'd13, 4'd12, 4'd0, 4'd5, 4'd10,
      4'd3, 4'd13, 4'd4, 4'd7, 4'd15, 4'd2, 4'd8, 4'd14,
      4'd12, 4'd0, 4'd1, 4'd10, 4'd6, 4'd9, 4'd11, 4'd5,
      4'd0, 4'd14, 4'd7, 4'd11, 4'd10, 4'd4, 4'd13, 4'd1,
      4'd5, 4'd8, 4'd12, 4'd6, 4'd9, 4'd3, 4'd2, 4'd15,
      4'd13, 4'd8, 4'd10, 4'd1, 4'd3, 4'd15, 4'd4, 4'd2,
      4'd11, 4'd6, 4'd7, 4'd12, 4'd0, 4'd5, 4'd14, 4'd9},
    '{4'd10, 4'd0, 4'd9, 4'd14, 4'd6, 4'd3, 4'd15, 4'd5,
      4'd1, 4'd13, 4'd12, 4'd7, 4'd11, 4'd4, 4'd2, 4'd8,
      4'd13, 4'd7, 4'd0, 4'd9, 4'd3, 4'd4, 4'd6, 4'd10,
      4'd2, 4'd8, 4'd5, 4'd14, 4'd12, 4'd11, 4'd15, 4'd1,
      4'd13, 4'd6, 4'd4, 4'd9, 4'd8, 4'd15, 4'd3, 4'd0,
      4'd11, 4'd1, 4'd2, 4'd12, 4'd5, 4'd10, 4'd14, 4'd7,
      4'd1, 4'd10, 4'd13, 4'd0, 4'd6, 4'd9, 4'd8, 4'd7,
      4'd4, 4'd15, 4'd14, 4'd3, 4'd11, 4'd5, 4'd2, 4'd12},
    '{4'd7, 4'd13, 4'd14, 4'd3, 4'd0, 4'd6, 4'd9, 4'd10,
      4'd1, 4'd2, 4'd8, 4'd5, 4'd11, 4'd12, 4'd4, 4'd15,
      4'd13, 4'd8, 4'd11, 4'd5, 4'd6, 4'd15, 4'd0, 4'd3,
      4'd4, 4'd7, 4'd2, 4'd12, 4'd1, 4'd10, 4'd14, 4'd9,
      4'd10, 4'd6, 4'd9, 4'd0, 4'd12, 4'd11, 4'd7, 4'd13,
      4'd15, 4'd1, 4'd3, 4'd14, 4'd5, 4'd2, 4'd8, 4'd4,
      4'd3, 4'd15, 4'd0, 4'd6, 4'd10, 4'd1, 4'd13, 4'd8,
      4'd9, 4'd4, 4'd5, 4'd11, 4'd12, 4'd7, 4'd2, 4'd14},
    '{4'd2, 4'd12, 4'd4, 4'd1, 4'd7, 4'd10, 4'd11, 4'd6,
      4'd8, 4'd5, 4'd3, 4'd15, 4'd13, 4'd0, 4'd14, 4'd9,
      4'd14, 4'd11, 4'd2, 4'd12, 4'd4, 4'd7, 4'd13, 4'd1,
      4'd5, 4'd0, 4'd15, 4'd10, 4'd3, 4'd9, 4'd8, 4'd6,
      4'd4, 4'd2, 4'd1, 4'd11, 4'd10, 4'd13, 4'd7, 4'd8,
      4'd15, 4'd9, 4'd12, 4'd5, 4'd6, 4'd3, 4'd0, 4'd14,
      4'd11, 4'd8, 4'd12, 4'd7, 4'd1, 4'd14, 4'd2, 4'd13,
      4'd6, 4'd15, 4'd0, 4'd9, 4'd10, 4'd4, 4'd5, 4'd3},
    '{4'd12, 4'd1, 4'd10, 4'd15, 4'd9, 4'd2, 4'd6, 4'd8,
      4'd0, 4'd13, 4'd3, 4'd4, 4'd14, 4'd7, 4'd5, 4'd11,
      4'd10, 4'd15, 4'd4, 4'd2, 4'd7, 4'd12, 4'd9, 4'd5,
      4'd6, 4'd1, 4'd13, 4'd14, 4'd0, 4'd11, 4'd3, 4'd8,
      4'd9, 4'd14, 4'd15, 4'd5, 4'd2, 4'd8, 4'd12, 4'd3,
      4'd7, 4'd0, 4'd4, 4'd10, 4'd1, 4'd13, 4'd11, 4'd6,
      4'd4, 4'd3, 4'd2, 4'd12, 4'd9, 4'd5, 4'd15, 4'd10,
      4'd11, 4'd14, 4'd1, 4'd7, 4'd6, 4'd0, 4'd8, 4'd13},
    '{4'd4, 4'd11, 4'd2, 4'd14, 4'd15, 4'd0, 4'd8, 4'd13,
      4'd3, 4'd12, 4'd9, 4'd7, 4'd5, 4'd10, 4'd6, 4'd1,
      4'd13, 4'd0, 4'd11, 4'd7, 4'd4, 4'd9, 4'd1, 4'd10,
      4'd14, 4'd3, 4'd5, 4'd12, 4'd2, 4'd15, 4'd8, 4'd6,
      4'd1, 4'd4, 4'd11, 4'd13, 4'd12, 4'd3, 4'd7, 4'd14,
      4'd10, 4'd15, 4'd6, 4'd8, 4'd0, 4'd5, 4'd9, 4'd2,
      4'd6, 4'd11, 4'd13, 4'd8, 4'd1, 4'd4, 4'd10, 4'd7,
      4'd9, 4'd5, 4'd0, 4'd15, 4'd14, 4'd2, 4'd3, 4'd12},
    '{4'd13, 4'd2, 4'd8, 4'd4, 4'd6, 4'd15, 4'd11, 4'd1,
      4'd10, 4'd9, 4'd3, 4'd14, 4'd5, 4'd0, 4'd12, 4'd7,
      4'd1, 4'd15, 4'd13, 4'd8, 4'd10, 4'd3, 4'd7, 4'd4,
      4'd12, 4'd5, 4'd6, 4'd11, 4'd0, 4'd14, 4'd9, 4'd2,
      4'd7, 4'd11, 4'd4, 4'd1, 4'd9, 4'd12, 4'd14, 4'd2,
      4'd0, 4'd6, 4'd10, 4'd13, 4'd15, 4'd3, 4'd5, 4'd8,
      4'd2, 4'd1, 4'd14, 4'd7, 4'd4, 4'd10, 4'd8, 4'd13,
      4'd15, 4'd12, 4'd9, 4'd0, 4'd3, 4'd5, 4'd6, 4'd11}
  };

  // E: 32 -> 48 bits; DES position p maps to bit 32-p
  function automatic key_t des_expand(half_t r);
    key_t e;
    for (int i = 0; i < KeyW; i++) begin
      e[KeyW-1-i] = r[5'(6'd32 - ExpandTab[i])];
    end
    return e;
  endfunction

  // S layer: eight 6-bit groups, row = outer bits, column = middle four
  function automatic half_t des_subst(key_t x);
    half_t    s;
    logic [5:0] grp;
    for (int b = 0; b < NumSbox; b++) begin
      grp = x[KeyW-1-6*b -: 6];
      s[HalfW-1-4*b -: 4] = SboxTab[b][{grp[5], grp[0], grp[4:1]}];
    end
    return s;
  endfunction

  function automatic half_t des_permute(half_t s);
    half_t p;
    for (int i = 0; i < HalfW; i++) begin
      p[HalfW-1-i] = s[5'(6'd32 - PermTab[i])];
    end
    return p;
  endfunction

endpackage

### hdl/drf_if.sv
// Valid/ready stream interfaces for the DES round function: the half-block input
// channel and the f result channel. Depends on drf_pkg.
interface drf_in_if;
  logic                      valid;
  logic                      ready;
  logic [drf_pkg::HalfW-1:0] right_half;

  modport source (output valid, output right_half, input ready);
  modport sink   (input valid, input right_half, output ready);
endinterface

interface drf_out_if;
  logic                      valid;
  logic                      ready;
  logic [drf_pkg::HalfW-1:0] f_result;

  modport source (output valid, output f_result, input ready);
  modport sink   (input valid, input f_result, output ready);
endinterface

### hdl/drf_feistel.sv
// Combinational DES f function: expansion, key mix, S-boxes, permutation P.
// Depends on drf_pkg.
module drf_feistel (
  input  logic [drf_pkg::HalfW-1:0] right_half_i,
  input  logic [drf_pkg::KeyW-1:0]  subkey_i,
  output logic [drf_pkg::HalfW-1:0] f_result_o
);
  import drf_pkg::*;

  key_t  mixed;
  half_t subst;

  always_comb begin
    mixed      = des_expand(right_half_i) ^ subkey_i;
    subst      = des_subst(mixed);
    f_result_o = des_permute(subst);
  end

endmodule

### hdl/des_round_function.sv
// DES round function top level: subkey register, input register, result register.
// Depends on drf_pkg, drf_if and drf_feistel.

// Computes f(R, K) = P(S(E(R) xor K)) on each 32-bit half block. A word is taken every
// cycle while the output is not stalled. The input register takes the word, and the
// result register takes its f value from the f logic and offers it on the output.
// The subkey is written through subkey_we_i / subkey_i and resets to zero; write it
// only when no word is in flight. Stalls on the output back up through both registers,
// so up to two words may be held.
module des_round_function (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     subkey_we_i,
  input  logic [drf_pkg::KeyW-1:0] subkey_i,
  drf_in_if.sink                   in_if,
  drf_out_if.source                out_if
);
  import drf_pkg::*;

  key_t  subkey_q;
  logic  in_valid_q;
  half_t in_data_q;
  logic  out_valid_q;
  half_t out_data_q;
  half_t f_value;
  logic  out_free;
  logic  in_free;

  assign out_free    = !out_valid_q || out_if.ready;
  assign in_free     = !in_valid_q || out_free;
  assign in_if.ready = in_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      subkey_q <= '0;
    end else if (subkey_we_i) begin
      subkey_q <= subkey_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_free) begin
        in_valid_q <= in_if.valid;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_free && in_if.valid) begin
      in_data_q <= in_if.right_half;
    end
    if (out_free && in_valid_q) begin
      out_data_q <= f_value;
    end
  end

  drf_feistel u_feistel (
    .right_half_i (in_data_q),
    .subkey_i     (subkey_q),
    .f_result_o   (f_value)
  );

  assign out_if.valid    = out_valid_q;
  assign out_if.f_result = out_data_q;

endmodule
